### hw/rtl/mbpa_pkg.sv
`default_nettype none
package mbpa_pkg;

    localparam int DEF_MAX_REGION_COUNT = 16;
    localparam int DEF_PAGE_BYTES       = 4096;

    localparam int ADDR_W = 32;

    localparam logic [31:0] LOW_LIMIT_RESET = 32'h0010_0000;
    localparam logic [31:0] USABLE_RAM_TYPE = 32'd1;

    localparam logic [1:0] KIND_ADD   = 2'd0;
    localparam logic [1:0] KIND_PAGE  = 2'd1;
    localparam logic [1:0] KIND_BYTES = 2'd2;

    typedef enum logic [1:0] {
        ST_ALLOCATED = 2'd0,
        ST_ADDED     = 2'd1,
        ST_IGNORED   = 2'd2,
        ST_NO_MEMORY = 2'd3
    } status_t;

endpackage
`default_nettype wire

### hw/rtl/mbpa_region_mem.sv
`default_nettype none
module mbpa_region_mem #(
    parameter int DEPTH = 16,
    parameter int AW    = 4,
    parameter int DW    = 85
) (
    input  wire logic          aclk,
    input  wire logic          wr_en,
    input  wire logic [AW-1:0] wr_addr,
    input  wire logic [DW-1:0] wr_data,
    input  wire logic [AW-1:0] rd_addr,
    output logic      [DW-1:0] rd_data_reg
);

    logic [DW-1:0] mem [DEPTH];

    always_ff @(posedge aclk) begin
        if (wr_en) begin
            mem[wr_addr] <= wr_data;
        end
        rd_data_reg <= mem[rd_addr];
    end

endmodule
`default_nettype wire

### hw/rtl/mbpa_ctrl.sv
`default_nettype none
module mbpa_ctrl #(
    parameter int MAX_REGION_COUNT = 16,
    parameter int PAGE_BYTES       = 4096
) (
    input  wire logic                    aclk,
    input  wire logic                    aresetn,
    input  wire logic [31:0]             low_limit,
    input  wire logic                    s_tvalid,
    output logic                         s_tready,
    input  wire logic [127:0]            s_tdata,
    input  wire logic [1:0]              s_tuser,
    output logic                         m_tvalid,
    input  wire logic                    m_tready,
    output logic [31:0]                  m_tdata,
    output mbpa_pkg::status_t            m_tuser
);
    import mbpa_pkg::*;

    localparam int PAGE_SHIFT = $clog2(PAGE_BYTES);
    localparam int USED_W     = 33 - PAGE_SHIFT;
    localparam int IDX_W      = (MAX_REGION_COUNT > 1) ? $clog2(MAX_REGION_COUNT) : 1;
    localparam int CNT_W      = $clog2(MAX_REGION_COUNT + 1);
    localparam int DW         = 2 * ADDR_W + USED_W;

    typedef enum logic [2:0] {
        S_IDLE = 3'b001,
        S_SCAN = 3'b010,
        S_RESP = 3'b100
    } state_t;

    state_t             state_reg, state_next;
    logic [IDX_W-1:0]   idx_reg, idx_next;
    logic [CNT_W-1:0]   count_reg, count_next;
    logic [USED_W-1:0]  pages_reg, pages_next;
    status_t            res_status_reg, res_status_next;
    logic [31:0]        res_addr_reg, res_addr_next;
    logic               m_tvalid_reg, m_tvalid_next;
    status_t            m_tuser_reg, m_tuser_next;
    logic [31:0]        m_tdata_reg, m_tdata_next;

    logic               wr_en;
    logic [IDX_W-1:0]   wr_addr;
    logic [DW-1:0]      wr_data;
    logic [DW-1:0]      rd_data;

    logic [31:0]        in_type, in_base, in_len, in_req;
    logic [32:0]        req_round;
    logic [USED_W-1:0]  req_pages;
    logic               add_ok;

    logic [31:0]        rg_start, rg_size;
    logic [USED_W-1:0]  rg_used;
    logic [USED_W:0]    fit_sum;
    logic               fits;
    logic               idx_last;
    logic               out_free;
    logic               accept;

    assign in_type = s_tdata[31:0];
    assign in_base = s_tdata[63:32];
    assign in_len  = s_tdata[95:64];
    assign in_req  = s_tdata[127:96];

    assign req_round = {1'b0, in_req} + 33'(PAGE_BYTES - 1);
    assign req_pages = USED_W'(req_round >> PAGE_SHIFT);
    assign add_ok    = (in_type == USABLE_RAM_TYPE) && (in_base >= low_limit)
                       && (count_reg < CNT_W'(MAX_REGION_COUNT));

    assign rg_start = rd_data[31:0];
    assign rg_size  = rd_data[63:32];
    assign rg_used  = rd_data[64 +: USED_W];
    assign fit_sum  = {1'b0, rg_used} + {1'b0, pages_reg};
    assign fits     = 32'(fit_sum) <= (rg_size >> PAGE_SHIFT);
    assign idx_last = (CNT_W'(idx_reg) + CNT_W'(1)) == count_reg;

    assign s_tready = (state_reg == S_IDLE);
    assign accept   = s_tvalid && s_tready;
    assign out_free = !m_tvalid_reg || m_tready;

    assign m_tvalid = m_tvalid_reg;
    assign m_tdata  = m_tdata_reg;
    assign m_tuser  = m_tuser_reg;

    mbpa_region_mem #(
        .DEPTH (MAX_REGION_COUNT),
        .AW    (IDX_W),
        .DW    (DW)
    ) u_mem (
        .aclk        (aclk),
        .wr_en       (wr_en),
        .wr_addr     (wr_addr),
        .wr_data     (wr_data),
        .rd_addr     (idx_next),
        .rd_data_reg (rd_data)
    );

    always_comb begin
        state_next      = state_reg;
        idx_next        = idx_reg;
        count_next      = count_reg;
        pages_next      = pages_reg;
        res_status_next = res_status_reg;
        res_addr_next   = res_addr_reg;
        m_tvalid_next   = m_tvalid_reg && !m_tready;
        m_tuser_next    = m_tuser_reg;
        m_tdata_next    = m_tdata_reg;
        wr_en           = 1'b0;
        wr_addr         = idx_reg;
        wr_data         = {USED_W'(fit_sum), rg_size, rg_start};

        case (state_reg)
            S_IDLE: begin
                if (accept) begin
                    res_addr_next   = '0;
                    res_status_next = ST_IGNORED;
                    idx_next        = '0;
                    state_next      = S_RESP;
                    case (s_tuser)
                        KIND_ADD: begin
                            if (add_ok) begin
                                wr_en           = 1'b1;
                                wr_addr         = IDX_W'(count_reg);
                                wr_data         = {USED_W'(0), in_len, in_base};
                                count_next      = count_reg + CNT_W'(1);
                                res_status_next = ST_ADDED;
                            end
                        end
                        KIND_PAGE, KIND_BYTES: begin
                            pages_next = (s_tuser == KIND_PAGE) ? USED_W'(1) : req_pages;
                            if (count_reg == '0) begin
                                res_status_next = ST_NO_MEMORY;
                            end else begin
                                state_next = S_SCAN;
                            end
                        end
                        default: begin
                            res_status_next = ST_IGNORED;
                        end
                    endcase
                end
            end
            S_SCAN: begin
                if (fits) begin
                    wr_en           = 1'b1;
                    res_status_next = ST_ALLOCATED;
                    res_addr_next   = rg_start + 32'({rg_used, {PAGE_SHIFT{1'b0}}});
                    state_next      = S_RESP;
                end else if (idx_last) begin
                    res_status_next = ST_NO_MEMORY;
                    state_next      = S_RESP;
                end else begin
                    idx_next = idx_reg + IDX_W'(1);
                end
            end
            S_RESP: begin
                if (out_free) begin
                    m_tvalid_next = 1'b1;
                    m_tuser_next  = res_status_reg;
                    m_tdata_next  = res_addr_reg;
                    state_next    = S_IDLE;
                end
            end
            default: begin
                state_next = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg    <= S_IDLE;
            count_reg    <= '0;
            idx_reg      <= '0;
            m_tvalid_reg <= 1'b0;
        end else begin
            state_reg    <= state_next;
            count_reg    <= count_next;
            idx_reg      <= idx_next;
            m_tvalid_reg <= m_tvalid_next;
        end
        pages_reg      <= pages_next;
        res_status_reg <= res_status_next;
        res_addr_reg   <= res_addr_next;
        m_tuser_reg    <= m_tuser_next;
        m_tdata_reg    <= m_tdata_next;
    end

endmodule
`default_nettype wire

### hw/rtl/multi_region_bump_page_allocator.sv
`default_nettype none
// Channel | Dir | Handshake          | Payload
// s_      | in  | s_tvalid/s_tready  | tdata: entry_type, region_base, region_length,
//         |     |                    |        request_size; tuser: kind
// m_      | out | m_tvalid/m_tready  | tdata: address; tuser: status
// cfg_    | in  | cfg_valid/cfg_ready| cfg_data: low_memory_limit
//
// Add and ignored requests go from S_IDLE to S_RESP, where the result enters the output
// register once it is free; the next request is taken back in S_IDLE. Allocate requests on a
// non-empty table first scan it first-fit in S_SCAN (at most MAX_REGION_COUNT regions, one
// region table read per cycle), then pass through S_RESP. One request is in flight at a time.
// Synchronous active-low reset empties the table; no clearing pass is needed.
// A waiting result sits in the output register while the next request enters;
// the following result waits until that register is taken.
module multi_region_bump_page_allocator #(
    parameter int MAX_REGION_COUNT = mbpa_pkg::DEF_MAX_REGION_COUNT,
    parameter int PAGE_BYTES       = mbpa_pkg::DEF_PAGE_BYTES
) (
    input  wire logic          aclk,
    input  wire logic          aresetn,
    input  wire logic          s_tvalid,
    output logic               s_tready,
    input  wire logic [127:0]  s_tdata,   // [31:0] entry_type, [63:32] region_base,
                                          // [95:64] region_length, [127:96] request_size
    input  wire logic [1:0]    s_tuser,   // [1:0] kind
    output logic               m_tvalid,
    input  wire logic          m_tready,
    output logic [31:0]        m_tdata,   // [31:0] address
    output mbpa_pkg::status_t  m_tuser,   // [1:0] status
    input  wire logic          cfg_valid,
    output logic               cfg_ready,
    input  wire logic [31:0]   cfg_data   // [31:0] low_memory_limit
);
    import mbpa_pkg::*;

    logic [31:0] low_limit_reg, low_limit_next;

    assign cfg_ready      = 1'b1;
    assign low_limit_next = (cfg_valid && cfg_ready) ? cfg_data : low_limit_reg;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            low_limit_reg <= LOW_LIMIT_RESET;
        end else begin
            low_limit_reg <= low_limit_next;
        end
    end

    mbpa_ctrl #(
        .MAX_REGION_COUNT (MAX_REGION_COUNT),
        .PAGE_BYTES       (PAGE_BYTES)
    ) u_ctrl (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .low_limit (low_limit_reg),
        .s_tvalid  (s_tvalid),
        .s_tready  (s_tready),
        .s_tdata   (s_tdata),
        .s_tuser   (s_tuser),
        .m_tvalid  (m_tvalid),
        .m_tready  (m_tready),
        .m_tdata   (m_tdata),
        .m_tuser   (m_tuser)
    );

    a_one_in_flight: assert property (@(posedge aclk) disable iff (!aresetn)
        s_tvalid && s_tready |=> !s_tready)
        else $error("request accepted while another is in progress");

    a_zero_addr_unless_alloc: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid && (m_tuser != ST_ALLOCATED) |-> (m_tdata == 32'd0))
        else $error("non-allocation result carries an address");

    a_reset_clears: assert property (@(posedge aclk)
        !aresetn |=> !m_tvalid && s_tready && (low_limit_reg == LOW_LIMIT_RESET))
        else $error("reset state wrong");

endmodule
`default_nettype wire

### test/tb_multi_region_bump_page_allocator.sv
module tb_multi_region_bump_page_allocator;
    import mbpa_pkg::*;

    localparam int          SLOT_COUNT   = DEF_MAX_REGION_COUNT;
    localparam int          PG_BYTES     = DEF_PAGE_BYTES;
    localparam logic [1:0]  KIND_UNKNOWN = 2'd3;
    localparam int          SEGMENT_SIZE = 215;

    typedef struct packed {
        logic [1:0]  kind;
        logic [31:0] entry_type;
        logic [31:0] region_base;
        logic [31:0] region_length;
        logic [31:0] request_size;
    } alloc_req_t;

    typedef struct packed {
        status_t     status;
        logic [31:0] address;
    } alloc_reply_t;

    logic          aclk      = 1'b0;
    logic          aresetn   = 1'b0;
    logic          s_tvalid  = 1'b0;
    logic          s_tready;
    logic [127:0]  s_tdata   = '0;
    logic [1:0]    s_tuser   = KIND_ADD;
    logic          m_tvalid;
    logic          m_tready  = 1'b0;
    logic [31:0]   m_tdata;
    status_t       m_tuser;
    logic          cfg_valid = 1'b0;
    logic          cfg_ready;
    logic [31:0]   cfg_data  = '0;

    logic [31:0]   low_limit = LOW_LIMIT_RESET;
    logic [31:0]   region_start [SLOT_COUNT];
    logic [31:0]   region_size  [SLOT_COUNT];
    logic [20:0]   region_used  [SLOT_COUNT];
    int            region_total = 0;

    alloc_reply_t  pending_replies[$];
    status_t       last_status;
    bit            free_run    = 1'b0;
    int            ready_hold  = 0;
    int            errors      = 0;
    int            n_requests  = 0;
    int            n_granted   = 0;
    int            n_refused   = 0;
    int            n_added     = 0;
    int            n_dropped   = 0;

    multi_region_bump_page_allocator u_dut (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .s_tvalid  (s_tvalid),
        .s_tready  (s_tready),
        .s_tdata   (s_tdata),
        .s_tuser   (s_tuser),
        .m_tvalid  (m_tvalid),
        .m_tready  (m_tready),
        .m_tdata   (m_tdata),
        .m_tuser   (m_tuser),
        .cfg_valid (cfg_valid),
        .cfg_ready (cfg_ready),
        .cfg_data  (cfg_data)
    );

    always #5 aclk = ~aclk;

    function automatic void predict_allocator(input alloc_req_t rq, output alloc_reply_t rp);
        logic [63:0] pages;
        logic [63:0] used_bytes;
        bit          granted;
        rp.status  = ST_IGNORED;
        rp.address = '0;
        granted    = 1'b0;
        case (rq.kind)
            KIND_ADD: begin
                if (rq.entry_type == USABLE_RAM_TYPE && rq.region_base >= low_limit &&
                    region_total < SLOT_COUNT) begin
                    region_start[region_total] = rq.region_base;
                    region_size[region_total]  = rq.region_length;
                    region_used[region_total]  = '0;
                    region_total++;
                    rp.status = ST_ADDED;
                end
            end
            KIND_PAGE, KIND_BYTES: begin
                if (rq.kind == KIND_PAGE)
                    pages = 64'd1;
                else
                    pages = (64'(rq.request_size) + 64'(PG_BYTES) - 64'd1) / 64'(PG_BYTES);
                rp.status = ST_NO_MEMORY;
                for (int i = 0; i < region_total && !granted; i++) begin
                    used_bytes = 64'(region_used[i]) * 64'(PG_BYTES);
                    if (used_bytes + pages * 64'(PG_BYTES) <= 64'(region_size[i])) begin
                        rp.status      = ST_ALLOCATED;
                        rp.address     = 32'(64'(region_start[i]) + used_bytes);
                        region_used[i] = 21'(64'(region_used[i]) + pages);
                        granted        = 1'b1;
                    end
                end
            end
            default: ;
        endcase
    endfunction

    function automatic int pick_gap();
        int r;
        r = $urandom_range(0, 99);
        if (free_run || r < 50)
            return 0;
        else if (r < 85)
            return $urandom_range(1, 3);
        else if (r < 97)
            return $urandom_range(4, 10);
        else
            return $urandom_range(20, 60);
    endfunction

    always @(posedge aclk) begin
        if (ready_hold > 0) begin
            ready_hold <= ready_hold - 1;
        end else if (free_run) begin
            m_tready <= 1'b1;
        end else begin
            case ($urandom_range(0, 19))
                0:          begin m_tready <= 1'b0; ready_hold <= $urandom_range(20, 60); end
                1, 2:       begin m_tready <= 1'b0; ready_hold <= $urandom_range(4, 15); end
                3, 4, 5, 6,
                7, 8:       begin m_tready <= 1'b0; ready_hold <= $urandom_range(0, 3); end
                default:    begin m_tready <= 1'b1; ready_hold <= $urandom_range(0, 8); end
            endcase
        end
    end

    always @(posedge aclk) begin
        alloc_reply_t exp_r;
        if (aresetn && m_tvalid && m_tready) begin
            if (pending_replies.size() == 0) begin
                $display("%0t: unexpected reply status %0d address %h", $time, m_tuser, m_tdata);
                errors++;
            end else begin
                exp_r = pending_replies.pop_front();
                if (m_tuser !== exp_r.status) begin
                    $display("%0t: status expected %0d actual %0d", $time, exp_r.status, m_tuser);
                    errors++;
                end
                if (m_tdata !== exp_r.address) begin
                    $display("%0t: address expected %h actual %h", $time, exp_r.address, m_tdata);
                    errors++;
                end
            end
        end
    end

    task automatic send_request(input logic [1:0] kind, input logic [31:0] etype,
                                input logic [31:0] base, input logic [31:0] len,
                                input logic [31:0] req);
        alloc_req_t   rq;
        alloc_reply_t rp;
        int           gap;
        rq = '{kind: kind, entry_type: etype, region_base: base, region_length: len,
               request_size: req};
        s_tvalid <= 1'b1;
        s_tdata  <= {req, len, base, etype};
        s_tuser  <= kind;
        do @(posedge aclk); while (!s_tready);
        predict_allocator(rq, rp);
        pending_replies.push_back(rp);
        last_status = rp.status;
        n_requests++;
        case (rp.status)
            ST_ALLOCATED: n_granted++;
            ST_NO_MEMORY: n_refused++;
            ST_ADDED:     n_added++;
            default:      n_dropped++;
        endcase
        gap = pick_gap();
        if (gap > 0) begin
            s_tvalid <= 1'b0;
            repeat (gap) @(posedge aclk);
        end
    endtask

    task automatic drain_replies();
        s_tvalid <= 1'b0;
        while (pending_replies.size() != 0) @(posedge aclk);
    endtask

    task automatic write_low_limit(input logic [31:0] value);
        cfg_valid <= 1'b1;
        cfg_data  <= value;
        do @(posedge aclk); while (!cfg_ready);
        cfg_valid <= 1'b0;
        low_limit = value;
    endtask

    task automatic test_empty_table();
        send_request(KIND_PAGE, $urandom, $urandom, $urandom, $urandom);
        send_request(KIND_BYTES, $urandom, $urandom, $urandom, 32'd0);
        send_request(KIND_UNKNOWN, $urandom, $urandom, $urandom, $urandom);
    endtask

    task automatic test_add_filtering();
        send_request(KIND_ADD, 32'd0, 32'h0020_0000, 32'h0001_0000, $urandom);
        send_request(KIND_ADD, 32'hFFFF_FFFF, 32'h0020_0000, 32'h0001_0000, $urandom);
        send_request(KIND_ADD, USABLE_RAM_TYPE, LOW_LIMIT_RESET - 1, 32'h0001_0000, $urandom);
        send_request(KIND_ADD, USABLE_RAM_TYPE, LOW_LIMIT_RESET, 32'd0, $urandom);
    endtask

    task automatic test_page_wrap();
        send_request(KIND_ADD, USABLE_RAM_TYPE, 32'hFFFF_F000, 32'h0000_3000, $urandom);
        send_request(KIND_PAGE, $urandom, $urandom, $urandom, $urandom);
        send_request(KIND_BYTES, $urandom, $urandom, $urandom, 32'd1);
        send_request(KIND_BYTES, $urandom, $urandom, $urandom, 32'h0000_1000);
        send_request(KIND_PAGE, $urandom, $urandom, $urandom, $urandom);
        send_request(KIND_BYTES, $urandom, $urandom, $urandom, 32'd0);
    endtask

    task automatic test_oversize();
        send_request(KIND_ADD, USABLE_RAM_TYPE, 32'h1000_0000, 32'hFFFF_FFFF, $urandom);
        send_request(KIND_BYTES, $urandom, $urandom, $urandom, 32'hFFFF_FFFF);
        send_request(KIND_BYTES, $urandom, $urandom, $urandom, 32'hFFFF_F001);
        send_request(KIND_BYTES, $urandom, $urandom, $urandom, 32'hFFFF_F000);
        send_request(KIND_PAGE, $urandom, $urandom, $urandom, $urandom);
        send_request(KIND_UNKNOWN, 32'hFFFF_FFFF, 32'hFFFF_FFFF, 32'hFFFF_FFFF, 32'hFFFF_FFFF);
        drain_replies();
    endtask

    task automatic test_limit_extremes();
        write_low_limit(32'd0);
        send_request(KIND_ADD, USABLE_RAM_TYPE, 32'd0, 32'h0000_8000, $urandom);
        send_request(KIND_PAGE, $urandom, $urandom, $urandom, $urandom);
        drain_replies();
        write_low_limit(32'hFFFF_FFFF);
        send_request(KIND_ADD, USABLE_RAM_TYPE, 32'hFFFF_FFFE, 32'h0000_2000, $urandom);
        send_request(KIND_ADD, USABLE_RAM_TYPE, 32'hFFFF_FFFF, 32'h0000_2000, $urandom);
        send_request(KIND_BYTES, $urandom, $urandom, $urandom, 32'h0000_8000);
        drain_replies();
    endtask

    task automatic send_random_add();
        logic [31:0] etype;
        logic [31:0] base;
        logic [31:0] len;
        etype = $urandom;
        base  = $urandom;
        len   = $urandom;
        if ($urandom_range(0, 4) != 0) begin
            etype = USABLE_RAM_TYPE;
            case ($urandom_range(0, 9))
                0:       base = low_limit;
                1:       base = (low_limit != 0) ? low_limit - 1 : low_limit;
                default: base = $urandom_range(32'hFFFF_FFFF, low_limit);
            endcase
            case ($urandom_range(0, 9))
                7, 8:    len = $urandom;
                9:       len = 32'd0;
                default: len = 32'($urandom_range(0, 1024) * PG_BYTES) +
                               ($urandom_range(0, 1) ? $urandom_range(0, PG_BYTES - 1) : 0);
            endcase
        end
        send_request(KIND_ADD, etype, base, len, $urandom);
    endtask

    task automatic run_random_segment(input logic [31:0] limit, input bit steady);
        int          counted;
        int          r;
        logic [31:0] req;
        counted = 0;
        drain_replies();
        write_low_limit(limit);
        free_run = steady;
        while (counted < SEGMENT_SIZE) begin
            r = $urandom_range(0, 99);
            if (r < 12) begin
                send_random_add();
                if (last_status == ST_ADDED) counted++;
            end else if (r < 37) begin
                send_request(KIND_PAGE, $urandom, $urandom, $urandom, $urandom);
                counted++;
            end else if (r < 97) begin
                case ($urandom_range(0, 19))
                    12, 13, 14: req = 32'($urandom_range(1, 16) * PG_BYTES +
                                          $urandom_range(0, 2) - 1);
                    15, 16, 17: req = $urandom;
                    18, 19:     req = 32'd0;
                    default:    req = $urandom_range(0, 16 * PG_BYTES);
                endcase
                send_request(KIND_BYTES, $urandom, $urandom, $urandom, req);
                counted++;
            end else begin
                send_request(KIND_UNKNOWN, $urandom, $urandom, $urandom, $urandom);
            end
        end
        free_run = 1'b0;
    endtask

    task automatic test_random_traffic();
        run_random_segment(LOW_LIMIT_RESET, 1'b0);
        run_random_segment(32'd0, 1'b0);
        run_random_segment($urandom, 1'b1);
        run_random_segment(32'hFFFF_FFFF, 1'b0);
        run_random_segment($urandom_range(0, 32'h0100_0000), 1'b0);
        run_random_segment(LOW_LIMIT_RESET, 1'b0);
        drain_replies();
    endtask

    initial begin
        repeat (9) @(posedge aclk);
        aresetn <= 1'b1;
        test_empty_table();
        test_add_filtering();
        test_page_wrap();
        test_oversize();
        test_limit_extremes();
        test_random_traffic();
        repeat (40) @(posedge aclk);
        $display("covered %0d requests: %0d granted, %0d out of memory, %0d regions added,",
                 n_requests, n_granted, n_refused, n_added);
        $display("%0d ignored, over six low-memory limits including both extremes",
                 n_dropped);
        if (errors == 0)
            $display("tb_multi_region_bump_page_allocator: done, clean");
        else
            $display("tb_multi_region_bump_page_allocator: done, errors");
        $finish;
    end

    initial begin
        #10_000_000;
        $display("tb_multi_region_bump_page_allocator: done, errors");
        $finish;
    end

endmodule
